// ----- hw/rtl/i2clrt_pkg.sv -----
// Package for the length-prefixed I2C register target.
// Holds the event codes, the phase type, the read constants and the mode payload table.
// No dependencies.
`default_nettype none

package i2clrt_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_START_WRITE  = 3'd0,
    MODE_START_READ   = 3'd1,
    MODE_FINISH       = 3'd2,
    MODE_WRITE_BYTE   = 3'd3,
    MODE_BYTE_REQUEST = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WLEN  = 3'd1,
    PH_WDATA = 3'd2,
    PH_RLEN  = 3'd3,
    PH_RDATA = 3'd4
  } phase_t;

  localparam logic [BYTE_W-1:0] MODE_REGISTER_ADDR  = 8'h03;
  localparam logic [BYTE_W-1:0] MODE_PAYLOAD_LEN    = 8'd4;
  localparam logic [BYTE_W-1:0] READ_PAYLOAD_LENGTH = 8'd64;

  // ASCII "APP "
  function automatic logic [BYTE_W-1:0] mode_payload_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = 8'h41;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h50;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/i2clrt_ifs.sv -----
// Valid/ready channel interfaces for the length-prefixed I2C register target.
// Request channel carries one bus event, response channel one result; uses i2clrt_pkg.
`default_nettype none

interface i2clrt_req_if import i2clrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data;

  modport source (output valid, output mode, output data, input ready);
  modport sink   (input valid, input mode, input data, output ready);
endinterface

interface i2clrt_rsp_if import i2clrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              write_rejected;

  modport source (output valid, output read_data, output write_rejected, input ready);
  modport sink   (input valid, input read_data, input write_rejected, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/i2c_length_prefixed_register_target.sv -----
// Length-prefixed I2C register target: one bus event in, one result out.
// Registered path: an accepted request goes through the input register, then the result register.
// Throughput: one request per cycle while the output is not stalled; the phase update and byte select sit in one short
//   combinational pass between the input register and the result register.
// Reset: synchronous, active low; clears both stage valids and all phase/transfer state.
// Depends on i2clrt_pkg and the channel interfaces in i2clrt_ifs.sv.
`default_nettype none

module i2c_length_prefixed_register_target import i2clrt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  i2clrt_req_if.sink   in_if,
  i2clrt_rsp_if.source out_if
);

  // input stage
  logic              req_valid_r;
  logic [MODE_W-1:0] req_mode_r;
  logic [BYTE_W-1:0] req_data_r;

  // result stage
  logic              rsp_valid_r;
  logic [BYTE_W-1:0] rsp_read_data_r;
  logic              rsp_rejected_r;
  logic [BYTE_W-1:0] rsp_read_data_nxt;
  logic              rsp_rejected_nxt;

  // transfer state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] ptr_r, ptr_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic              modesel_r, modesel_nxt;

  logic              rsp_free;
  logic              stage_fire;
  logic [BYTE_W-1:0] pos_inc;

  assign rsp_free   = !rsp_valid_r || out_if.ready;
  assign stage_fire = req_valid_r && rsp_free;
  assign in_if.ready = !req_valid_r || rsp_free;
  assign pos_inc    = pos_r + 8'd1;

  assign out_if.valid          = rsp_valid_r;
  assign out_if.read_data      = rsp_read_data_r;
  assign out_if.write_rejected = rsp_rejected_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (stage_fire) begin
      case (req_mode_r)
        MODE_START_WRITE, MODE_FINISH: begin
          phase_nxt = PH_IDLE;
        end
        MODE_START_READ: begin
          phase_nxt = PH_RLEN;
        end
        MODE_WRITE_BYTE: begin
          case (phase_r)
            PH_IDLE:  phase_nxt = PH_WLEN;
            PH_WLEN:  phase_nxt = (req_data_r == '0) ? PH_IDLE : PH_WDATA;
            PH_WDATA: begin
              if (pos_inc >= len_r) phase_nxt = PH_IDLE;
            end
            default:  phase_nxt = phase_r;
          endcase
        end
        MODE_BYTE_REQUEST: begin
          if (phase_r == PH_RLEN) phase_nxt = PH_RDATA;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // transfer registers and result
  always_comb begin
    ptr_nxt           = ptr_r;
    len_nxt           = len_r;
    pos_nxt           = pos_r;
    modesel_nxt       = modesel_r;
    rsp_read_data_nxt = '0;
    rsp_rejected_nxt  = 1'b0;
    case (req_mode_r)
      MODE_START_WRITE, MODE_FINISH: begin
        len_nxt = '0;
        pos_nxt = '0;
      end
      MODE_START_READ: begin
        pos_nxt     = '0;
        modesel_nxt = (ptr_r == MODE_REGISTER_ADDR);
        len_nxt     = (ptr_r == MODE_REGISTER_ADDR) ? MODE_PAYLOAD_LEN : READ_PAYLOAD_LENGTH;
      end
      MODE_WRITE_BYTE: begin
        case (phase_r)
          PH_IDLE:  ptr_nxt = req_data_r;
          PH_WLEN: begin
            len_nxt = req_data_r;
            pos_nxt = '0;
          end
          PH_WDATA: pos_nxt = pos_inc;
          default:  rsp_rejected_nxt = 1'b1;
        endcase
      end
      MODE_BYTE_REQUEST: begin
        if (phase_r == PH_RLEN) begin
          rsp_read_data_nxt = len_r;
        end else if (phase_r == PH_RDATA && pos_r < len_r) begin
          if (modesel_r && pos_r < MODE_PAYLOAD_LEN) begin
            rsp_read_data_nxt = mode_payload_byte(pos_r[1:0]);
          end
          pos_nxt = pos_inc;
        end
      end
      default: begin
        ptr_nxt = ptr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      ptr_r       <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      modesel_r   <= 1'b0;
    end else begin
      if (in_if.ready) req_valid_r <= in_if.valid;
      if (rsp_free)    rsp_valid_r <= req_valid_r;
      phase_r <= phase_nxt;
      if (stage_fire) begin
        ptr_r     <= ptr_nxt;
        len_r     <= len_nxt;
        pos_r     <= pos_nxt;
        modesel_r <= modesel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      req_mode_r <= in_if.mode;
      req_data_r <= in_if.data;
    end
    if (stage_fire) begin
      rsp_read_data_r <= rsp_read_data_nxt;
      rsp_rejected_r  <= rsp_rejected_nxt;
    end
  end

  // a rejected write never carries read data
  assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_valid_r && rsp_rejected_r) |-> (rsp_read_data_r == '0))
    else $error("rejected write carries read data");

  // mode register reads always have the fixed short length
  assert property (@(posedge clk) disable iff (!rst_n)
    (modesel_r && (phase_r == PH_RLEN || phase_r == PH_RDATA))
      |-> (len_r == MODE_PAYLOAD_LEN))
    else $error("mode register read with wrong length");

  // read position never runs past the length
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RDATA) |-> (pos_r <= len_r))
    else $error("read position beyond transfer length");

endmodule

`default_nettype wire
